### hw/rtl/spcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared constants and types of the serial pin command parser: line length,
// character codes, action codes and the result record.
// ----------------------------------------------------------------------------
package spcp_pkg;

	// Longest kept line; bytes beyond it are not counted and are dropped.
	localparam int LINE_MAX = 63;
	localparam int CNT_W    = $clog2(LINE_MAX + 1);

	// Characters the parser looks at.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_UG    = 8'h47;
	localparam logic [7:0] CH_UI    = 8'h49;
	localparam logic [7:0] CH_UL    = 8'h4C;
	localparam logic [7:0] CH_UN    = 8'h4E;
	localparam logic [7:0] CH_UP    = 8'h50;
	localparam logic [7:0] CH_US    = 8'h53;
	localparam logic [7:0] CH_UT    = 8'h54;
	localparam logic [7:0] CH_UU    = 8'h55;
	localparam logic [7:0] CH_LA    = 8'h61;

	// Action codes of a result.
	localparam logic [1:0] ACT_PONG  = 2'd0;
	localparam logic [1:0] ACT_PULSE = 2'd1;
	localparam logic [1:0] ACT_SET   = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic       port_sel;
		logic [3:0] pin_index;
		logic       level;
	} result_t;

endpackage

### hw/rtl/spcp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_in_reg
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module spcp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import spcp_pkg::*;

	// The register can take a new byte when empty or when its byte leaves now.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### hw/rtl/spcp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_parser
// Byte-wise line parser: keeps the per-line state and decides, on a line
// end, whether the line held a valid command.
// ----------------------------------------------------------------------------
module spcp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  logic [7:0]          byte_in,
	input  logic                step,
	output logic                res_valid,
	output spcp_pkg::result_t   res
);
	import spcp_pkg::*;

	localparam logic [4:0] PH_START    = 5'd0;
	localparam logic [4:0] PH_P        = 5'd1;
	localparam logic [4:0] PH_PI       = 5'd2;
	localparam logic [4:0] PH_PIN      = 5'd3;
	localparam logic [4:0] PH_PU       = 5'd4;
	localparam logic [4:0] PH_PUL      = 5'd5;
	localparam logic [4:0] PH_PULS     = 5'd6;
	localparam logic [4:0] PH_PULSE    = 5'd7;
	localparam logic [4:0] PH_S        = 5'd8;
	localparam logic [4:0] PH_SE       = 5'd9;
	localparam logic [4:0] PH_SET      = 5'd10;
	localparam logic [4:0] PH_SKIP     = 5'd11;
	localparam logic [4:0] PH_PORT     = 5'd12;
	localparam logic [4:0] PH_N1_PRE   = 5'd13;
	localparam logic [4:0] PH_N1_SIGN  = 5'd14;
	localparam logic [4:0] PH_N1_DIG   = 5'd15;
	localparam logic [4:0] PH_PULSE_OK = 5'd16;
	localparam logic [4:0] PH_N2_PRE   = 5'd17;
	localparam logic [4:0] PH_N2_SIGN  = 5'd18;
	localparam logic [4:0] PH_N2_DIG   = 5'd19;
	localparam logic [4:0] PH_SET_OK   = 5'd20;
	localparam logic [4:0] PH_PONG_OK  = 5'd21;
	localparam logic [4:0] PH_DEAD     = 5'd22;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_PULSE = 2'd1;
	localparam logic [1:0] KIND_SET   = 2'd2;
	localparam logic [1:0] KIND_PING  = 2'd3;

	logic [CNT_W-1:0] count_q,  count_d;
	logic [4:0]       phase_q,  phase_d;
	logic [1:0]       kind_q,   kind_d;
	logic             port_b_q, port_b_d;
	logic [4:0]       pin_q,    pin_d;
	logic             neg_q,    neg_d;
	logic             lvl_q,    lvl_d;
	logic             ended_q,  ended_d;

	logic       is_eol;
	logic       is_blank;
	logic       is_digit;
	logic       is_sign;
	logic [7:0] pin_next;
	logic [4:0] pin_sat;
	logic       pin_ok;
	logic       pulse_ok;
	logic       set_ok;

	assign is_eol   = byte_in == CH_CR || byte_in == CH_LF;
	assign is_blank = byte_in == CH_SPACE || byte_in == CH_TAB ||
	                  byte_in == CH_VT || byte_in == CH_FF;
	assign is_digit = byte_in >= CH_ZERO && byte_in <= CH_NINE;
	assign is_sign  = byte_in == CH_PLUS || byte_in == CH_MINUS;

	// Pin magnitude times ten plus the new digit, held at 16 once past 15.
	assign pin_next = {pin_q, 3'b000} + {2'b00, pin_q, 1'b0} + {4'b0000, byte_in[3:0]};
	assign pin_sat  = (pin_next > 8'd15) ? 5'd16 : pin_next[4:0];

	// Minus zero is the only negative pin that passes.
	assign pin_ok   = pin_q <= 5'd15 && (!neg_q || pin_q == 5'd0);
	assign pulse_ok = kind_q == KIND_PULSE && pin_ok &&
	                  (phase_q == PH_N1_DIG || phase_q == PH_PULSE_OK);
	assign set_ok   = kind_q == KIND_SET && pin_ok &&
	                  (phase_q == PH_N2_DIG || phase_q == PH_SET_OK);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (valid && is_eol && count_q != '0) begin
			priority if (phase_q == PH_PONG_OK) begin
				res_valid  = 1'b1;
				res.action = ACT_PONG;
			end else if (pulse_ok) begin
				res_valid     = 1'b1;
				res.action    = ACT_PULSE;
				res.port_sel  = port_b_q;
				res.pin_index = pin_q[3:0];
			end else if (set_ok) begin
				res_valid     = 1'b1;
				res.action    = ACT_SET;
				res.port_sel  = port_b_q;
				res.pin_index = pin_q[3:0];
				res.level     = lvl_q;
			end else begin
				res_valid = 1'b0;
			end
		end
	end

	always_comb begin
		count_d  = count_q;
		phase_d  = phase_q;
		kind_d   = kind_q;
		port_b_d = port_b_q;
		pin_d    = pin_q;
		neg_d    = neg_q;
		lvl_d    = lvl_q;
		ended_d  = ended_q;
		if (is_eol) begin
			// An empty line leaves everything as it is.
			if (count_q != '0) begin
				count_d  = '0;
				phase_d  = PH_START;
				kind_d   = KIND_NONE;
				port_b_d = 1'b0;
				pin_d    = '0;
				neg_d    = 1'b0;
				lvl_d    = 1'b0;
				ended_d  = 1'b0;
			end
		end else if (count_q < CNT_W'(LINE_MAX)) begin
			count_d = count_q + 1'b1;
			if (!ended_q) begin
				if (byte_in == CH_NUL) begin
					ended_d = 1'b1;
				end else begin
					unique case (phase_q)
						PH_START: begin
							phase_d = (byte_in == CH_UP) ? PH_P :
							          (byte_in == CH_US) ? PH_S : PH_DEAD;
						end
						PH_P: begin
							phase_d = (byte_in == CH_UI) ? PH_PI :
							          (byte_in == CH_UU) ? PH_PU : PH_DEAD;
						end
						PH_PI:   phase_d = (byte_in == CH_UN) ? PH_PIN : PH_DEAD;
						PH_PIN: begin
							if (byte_in == CH_UG) begin
								phase_d = PH_PONG_OK;
								kind_d  = KIND_PING;
							end else begin
								phase_d = PH_DEAD;
							end
						end
						PH_PU:   phase_d = (byte_in == CH_UL) ? PH_PUL : PH_DEAD;
						PH_PUL:  phase_d = (byte_in == CH_US) ? PH_PULS : PH_DEAD;
						PH_PULS: phase_d = (byte_in == CH_UE) ? PH_PULSE : PH_DEAD;
						PH_PULSE: begin
							if (byte_in == CH_COLON) begin
								phase_d = PH_SKIP;
								kind_d  = KIND_PULSE;
							end else begin
								phase_d = PH_DEAD;
							end
						end
						PH_S:  phase_d = (byte_in == CH_UE) ? PH_SE : PH_DEAD;
						PH_SE: phase_d = (byte_in == CH_UT) ? PH_SET : PH_DEAD;
						PH_SET: begin
							if (byte_in == CH_COLON) begin
								phase_d = PH_SKIP;
								kind_d  = KIND_SET;
							end else begin
								phase_d = PH_DEAD;
							end
						end
						// The letter after the colon is taken without a check.
						PH_SKIP: phase_d = PH_PORT;
						PH_PORT: begin
							port_b_d = !(byte_in == CH_UA || byte_in == CH_LA);
							phase_d  = PH_N1_PRE;
						end
						PH_N1_PRE, PH_N1_SIGN: begin
							if (phase_q == PH_N1_PRE && is_blank) begin
								phase_d = PH_N1_PRE;
							end else if (phase_q == PH_N1_PRE && is_sign) begin
								neg_d   = byte_in == CH_MINUS;
								phase_d = PH_N1_SIGN;
							end else if (is_digit) begin
								pin_d   = pin_sat;
								phase_d = PH_N1_DIG;
							end else begin
								phase_d = PH_DEAD;
							end
						end
						PH_N1_DIG: begin
							if (is_digit) begin
								pin_d = pin_sat;
							end else if (kind_q == KIND_PULSE) begin
								phase_d = PH_PULSE_OK;
							end else begin
								phase_d = (byte_in == CH_COLON) ? PH_N2_PRE : PH_DEAD;
							end
						end
						PH_N2_PRE, PH_N2_SIGN, PH_N2_DIG: begin
							if (phase_q == PH_N2_PRE && is_blank) begin
								phase_d = PH_N2_PRE;
							end else if (phase_q == PH_N2_PRE && is_sign) begin
								phase_d = PH_N2_SIGN;
							end else if (is_digit) begin
								if (byte_in != CH_ZERO) begin
									lvl_d = 1'b1;
								end
								phase_d = PH_N2_DIG;
							end else begin
								phase_d = (phase_q == PH_N2_DIG) ? PH_SET_OK : PH_DEAD;
							end
						end
						default: phase_d = phase_q;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			phase_q  <= PH_START;
			kind_q   <= KIND_NONE;
			port_b_q <= 1'b0;
			pin_q    <= '0;
			neg_q    <= 1'b0;
			lvl_q    <= 1'b0;
			ended_q  <= 1'b0;
		end else if (step) begin
			count_q  <= count_d;
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			port_b_q <= port_b_d;
			pin_q    <= pin_d;
			neg_q    <= neg_d;
			lvl_q    <= lvl_d;
			ended_q  <= ended_d;
		end
	end

	a_res_only_on_eol: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (valid && is_eol && count_q != '0))
		else $error("result raised on a byte that does not end a line");

	a_eol_clears_line: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_eol && count_q != '0) |=> (count_q == '0 && phase_q == PH_START))
		else $error("line state not cleared after a line end");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LINE_MAX))
		else $error("kept character count past the line limit");

	a_pin_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pin_q <= 5'd16)
		else $error("pin magnitude past its saturation value");

	a_ended_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ended_q && !is_eol) |=> $stable(phase_q))
		else $error("parser moved after a zero byte ended the content");

endmodule

### hw/rtl/spcp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcp_out_reg
// Result register: holds one decoded command until the consumer takes it.
// ----------------------------------------------------------------------------
module spcp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  spcp_pkg::result_t res,
	output logic              slot_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        action,
	output logic              port_sel,
	output logic [3:0]        pin_index,
	output logic              level
);
	import spcp_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign action    = res_q.action;
	assign port_sel  = res_q.port_sel;
	assign pin_index = res_q.pin_index;
	assign level     = res_q.level;

endmodule

### hw/rtl/serial_pin_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_pin_command_parser
// Parses received serial text lines into pong, pulse-pin and set-pin commands.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle unless the input side stalls. Each
// accepted byte is held in an input register while the line parser updates its
// per-line state; a CR or LF that closes a line holding a valid PING,
// PULSE:P<port><n> or SET:P<port><n>:<v> command loads the result register,
// and out_valid is driven from that register, not combinationally.
// Only a line end whose result meets a full, unread result register waits, and
// then the input side stalls until the consumer takes the earlier transaction.
module serial_pin_command_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] action,
	output logic       port_sel,
	output logic [3:0] pin_index,
	output logic       level
);
	import spcp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	logic       slot_free;

	// A byte moves on unless it carries a result and the result register is busy.
	assign advance = valid_s1 && (!res_valid || slot_free);

	spcp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	spcp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.byte_in   (byte_s1),
		.step      (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	spcp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res       (res),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.port_sel  (port_sel),
		.pin_index (pin_index),
		.level     (level)
	);

endmodule
